/* sv/pdsel_pkg.sv */
// Shared types, constants and constant-divide helpers for the PDO selector.
package pdsel_pkg;

   localparam int unsigned MAX_OBJECTS = 7;

   localparam int unsigned POS_W     = 3;
   localparam int unsigned MV_W      = 14;
   localparam int unsigned MA_W      = 12;
   localparam int unsigned VQ_W      = 10;   // voltage in 20 mV units
   localparam int unsigned C10_W     = 9;    // current in 10 mA units
   localparam int unsigned C50_W     = 7;    // current in 50 mA units
   localparam int unsigned PROD_W    = MV_W + MA_W;
   localparam int unsigned PWR_W     = 17;
   localparam int unsigned LOW_W     = 19;   // operating fields of the request word
   localparam int unsigned PRI_W     = 2;
   localparam int unsigned CSR_IDX_W = 3;

   // Top five bits of an augmented programmable supply object.
   localparam logic [4:0] PPS_KIND   = 5'b11000;
   localparam logic [1:0] FIXED_KIND = 2'b00;

   localparam int unsigned MIN_MV        = 5000;
   localparam int unsigned MIN_MA        = 500;
   localparam int unsigned FIXED_V_STEP  = 50;
   localparam int unsigned FIXED_C_STEP  = 10;
   localparam int unsigned PPS_V_RANGE   = 100;
   localparam int unsigned PPS_V_STEP    = 20;
   localparam int unsigned PPS_C_STEP    = 50;
   localparam int unsigned PPS_HI_TO_VQ  = PPS_V_RANGE / PPS_V_STEP;
   localparam int unsigned MIN_VQ        = MIN_MV / PPS_V_STEP;
   localparam int unsigned MIN_C10       = MIN_MA / FIXED_C_STEP;
   localparam int unsigned MIN_C50       = MIN_MA / PPS_C_STEP;

   localparam logic [PRI_W-1:0] PRI_MATCH = 2'd2;
   localparam logic [PRI_W-1:0] PRI_OTHER = 2'd1;

   localparam logic [MV_W-1:0]    RST_MAX_MV  = 14'd5000;
   localparam logic [MV_W-1:0]    RST_PREF_MV = 14'd5000;
   localparam logic [VQ_W-1:0]    RST_MAX_VQ  = 10'd250;
   localparam logic [VQ_W-1:0]    RST_PREF_VQ = 10'd250;
   localparam logic [C10_W-1:0]   RST_MAX_C10 = 9'd50;
   localparam logic [C50_W-1:0]   RST_MAX_C50 = 7'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_VOLTAGE   = 3'd0,
      CSR_PREF_VOLTAGE  = 3'd1,
      CSR_MAX_CURRENT   = 3'd2,
      CSR_PPS_ENABLE    = 3'd3,
      CSR_PPS_PREFERRED = 3'd4,
      CSR_PPS_REFUSED   = 3'd5,
      CSR_PEER_REV30    = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic [31:0] supply_object;
      logic        is_last;
   } req_payload_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] object_position;
      logic [MV_W-1:0]  chosen_mv;
      logic [MA_W-1:0]  chosen_ma;
      logic             is_pps;
      logic [31:0]      request_word;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [MV_W-1:0]      data;
   } csr_payload_type;

   // Reciprocal multiplications; each is exact over the full input range.
   function automatic logic [VQ_W-1:0] div20_u14(input logic [MV_W-1:0] v);
      logic [24:0] p;
      p = {13'd0, v[13:2]} * 25'd3277;
      return p[23:14];
   endfunction

   function automatic logic [C10_W-1:0] div10_u12(input logic [MA_W-1:0] c);
      logic [23:0] p;
      p = {13'd0, c[11:1]} * 24'd3277;
      return p[22:14];
   endfunction

   function automatic logic [C50_W-1:0] div50_u12(input logic [MA_W-1:0] c);
      logic [23:0] p;
      p = {13'd0, c[11:1]} * 24'd2622;
      return p[22:16];
   endfunction

   function automatic logic [PWR_W-1:0] div1000_u26(input logic [PROD_W-1:0] x);
      logic [46:0] p;
      p = {24'd0, x[25:3]} * 47'd8589935;
      return p[46:30];
   endfunction

endpackage

/* sv/pdsel_if.sv */
// Handshake channel interfaces for the request, response and CSR ports.
interface pdsel_req_if;
   import pdsel_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pdsel_rsp_if;
   import pdsel_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pdsel_csr_if;
   import pdsel_pkg::*;
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* sv/pd_sink_pdo_selector.sv */
// USB PD sink power data object selector with request word builder.
// Stages: input, decode and compare; a last object's response is then registered.
// Throughput: one object per cycle, unless a last object finds the output register full.
// Non-final objects keep flowing while a response waits on the output register.
// Reset (synchronous) empties the pipeline, clears the scan and restores the CSR values.
module pd_sink_pdo_selector (
   input logic          clock,
   input logic          reset,
   pdsel_req_if.sink    req_ch,
   pdsel_rsp_if.source  rsp_ch,
   pdsel_csr_if.sink    csr_ch
);
   import pdsel_pkg::*;

   // Configuration, with the quotients needed by the datapath kept alongside.
   logic [MV_W-1:0]  max_mv_ff, pref_mv_ff;
   logic [VQ_W-1:0]  max_vq_ff, pref_vq_ff;
   logic [C10_W-1:0] max_c10_ff;
   logic [C50_W-1:0] max_c50_ff;
   logic             pps_en_ff, pps_pref_ff, pps_refused_ff, rev30_ff;

   logic             s0_valid_ff, s0_last_ff;
   logic [31:0]      s0_pdo_ff;

   logic             s1_valid_ff, s1_last_ff, s1_ok_ff, s1_pps_ff;
   logic [MV_W-1:0]  s1_v_ff, s1_dist_ff;
   logic [MA_W-1:0]  s1_c_ff;
   logic [PRI_W-1:0] s1_pri_ff;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [LOW_W-1:0] s1_low_ff;

   logic [POS_W-1:0] idx_ff, idx_in;
   logic [POS_W-1:0] best_pos_ff, best_pos_in;
   logic [PRI_W-1:0] best_pri_ff, best_pri_in;
   logic [MV_W-1:0]  best_v_ff, best_v_in, best_dist_ff, best_dist_in;
   logic [MA_W-1:0]  best_c_ff, best_c_in;
   logic             best_pps_ff, best_pps_in;
   logic [PWR_W-1:0] best_pw_ff, best_pw_in;
   logic [LOW_W-1:0] best_low_ff, best_low_in;

   logic             rsp_valid_ff;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   logic out_free, s1_fire, s1_open, s0_fire, s0_open;

   // Decode signals
   logic              pps_kind, fixed_kind, pps_allowed, cand_pps;
   logic [15:0]       v_fix;
   logic              fix_v_ok;
   logic [C10_W-1:0]  c10;
   logic [MA_W-1:0]   c_fix;
   logic [7:0]        hi_f, lo_f;
   logic [14:0]       lo_mv;
   logic              range_bad;
   logic [10:0]       hi_q, lo_q, vq_a, vq_b, vq;
   logic [MV_W-1:0]   v_pps;
   logic [C50_W-1:0]  c50;
   logic [MA_W-1:0]   c_pps;
   logic [MV_W-1:0]   d_v;
   logic [MA_W-1:0]   d_c;
   logic              d_ok;
   logic [LOW_W-1:0]  d_low;
   logic [PRI_W-1:0]  d_pri;
   logic [MV_W-1:0]   d_dist;
   logic [PROD_W-1:0] d_prod;

   // Compare signals
   logic [PWR_W-1:0] pw;
   logic             win, take;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_mv_ff      <= RST_MAX_MV;
         pref_mv_ff     <= RST_PREF_MV;
         max_vq_ff      <= RST_MAX_VQ;
         pref_vq_ff     <= RST_PREF_VQ;
         max_c10_ff     <= RST_MAX_C10;
         max_c50_ff     <= RST_MAX_C50;
         pps_en_ff      <= 1'b0;
         pps_pref_ff    <= 1'b0;
         pps_refused_ff <= 1'b0;
         rev30_ff       <= 1'b0;
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.payload.index))
            CSR_MAX_VOLTAGE: begin
               max_mv_ff <= csr_ch.payload.data;
               max_vq_ff <= div20_u14(csr_ch.payload.data);
            end
            CSR_PREF_VOLTAGE: begin
               pref_mv_ff <= csr_ch.payload.data;
               pref_vq_ff <= div20_u14(csr_ch.payload.data);
            end
            CSR_MAX_CURRENT: begin
               max_c10_ff <= div10_u12(csr_ch.payload.data[MA_W-1:0]);
               max_c50_ff <= div50_u12(csr_ch.payload.data[MA_W-1:0]);
            end
            CSR_PPS_ENABLE:    pps_en_ff      <= csr_ch.payload.data[0];
            CSR_PPS_PREFERRED: pps_pref_ff    <= csr_ch.payload.data[0];
            CSR_PPS_REFUSED:   pps_refused_ff <= csr_ch.payload.data[0];
            CSR_PEER_REV30:    rev30_ff       <= csr_ch.payload.data[0];
            default: ;
         endcase
      end
   end

   // Flow control: only a final object needs room in the output register.
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire  = s1_valid_ff && (!s1_last_ff || out_free);
   assign s1_open  = !s1_valid_ff || s1_fire;
   assign s0_fire  = s0_valid_ff && s1_open;
   assign s0_open  = !s0_valid_ff || s0_fire;
   assign req_ch.ready = s0_open;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ch.valid && s0_open) begin
         s0_valid_ff <= 1'b1;
      end else if (s0_fire) begin
         s0_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && s0_open) begin
         s0_pdo_ff  <= req_ch.payload.supply_object;
         s0_last_ff <= req_ch.payload.is_last;
      end
   end

   // Object decode. Voltages of a programmable supply are worked in 20 mV units,
   // so rounding down reduces to picking among values that are already multiples.
   always_comb begin
      pps_kind    = s0_pdo_ff[31:27] == PPS_KIND;
      fixed_kind  = s0_pdo_ff[31:30] == FIXED_KIND;
      pps_allowed = pps_en_ff && !pps_refused_ff && rev30_ff;
      cand_pps    = pps_kind && pps_allowed;

      v_fix    = {6'd0, s0_pdo_ff[19:10]} * 16'(FIXED_V_STEP);
      fix_v_ok = fixed_kind && (v_fix >= 16'(MIN_MV)) && (v_fix <= {2'd0, max_mv_ff});
      c10      = (s0_pdo_ff[9:0] <= {1'b0, max_c10_ff}) ? s0_pdo_ff[8:0] : max_c10_ff;
      c_fix    = {3'd0, c10} * 12'(FIXED_C_STEP);

      hi_f      = s0_pdo_ff[24:17];
      lo_f      = s0_pdo_ff[15:8];
      lo_mv     = {7'd0, lo_f} * 15'(PPS_V_RANGE);
      range_bad = (hi_f < lo_f) || ({1'b0, max_mv_ff} < lo_mv);
      hi_q      = {3'd0, hi_f} * 11'(PPS_HI_TO_VQ);
      lo_q      = {3'd0, lo_f} * 11'(PPS_HI_TO_VQ);
      vq_a      = (hi_q < {1'b0, max_vq_ff}) ? hi_q : {1'b0, max_vq_ff};
      vq_b      = (vq_a < {1'b0, pref_vq_ff}) ? vq_a : {1'b0, pref_vq_ff};
      vq        = (vq_b < lo_q) ? lo_q : vq_b;
      v_pps     = {4'd0, vq[VQ_W-1:0]} * 14'(PPS_V_STEP);
      c50       = (s0_pdo_ff[6:0] <= max_c50_ff) ? s0_pdo_ff[6:0] : max_c50_ff;
      c_pps     = {5'd0, c50} * 12'(PPS_C_STEP);

      if (cand_pps) begin
         d_v   = v_pps;
         d_c   = c_pps;
         d_ok  = !range_bad && (vq >= 11'(MIN_VQ)) && (c50 >= 7'(MIN_C50));
         d_low = {vq[VQ_W-1:0], 2'b00, c50};
      end else begin
         d_v   = v_fix[MV_W-1:0];
         d_c   = c_fix;
         d_ok  = fix_v_ok && (c10 >= 9'(MIN_C10));
         d_low = {c10, 1'b0, c10};
      end

      d_pri  = (cand_pps == pps_pref_ff) ? PRI_MATCH : PRI_OTHER;
      d_dist = (d_v >= pref_mv_ff) ? d_v - pref_mv_ff : pref_mv_ff - d_v;
      d_prod = {12'd0, d_v} * {14'd0, d_c};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s0_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_fire) begin
         s1_last_ff <= s0_last_ff;
         s1_ok_ff   <= d_ok;
         s1_pps_ff  <= cand_pps;
         s1_v_ff    <= d_v;
         s1_c_ff    <= d_c;
         s1_pri_ff  <= d_pri;
         s1_dist_ff <= d_dist;
         s1_prod_ff <= d_prod;
         s1_low_ff  <= d_low;
      end
   end

   // Ranking against the running best: power, then priority, then distance,
   // then the higher voltage.
   always_comb begin
      pw  = div1000_u26(s1_prod_ff);
      win = (best_pos_ff == '0) || (pw > best_pw_ff) ||
            ((pw == best_pw_ff) &&
             ((s1_pri_ff > best_pri_ff) ||
              ((s1_pri_ff == best_pri_ff) &&
               ((s1_dist_ff < best_dist_ff) ||
                ((s1_dist_ff == best_dist_ff) && (s1_v_ff > best_v_ff))))));
      take = s1_fire && (idx_ff < POS_W'(MAX_OBJECTS)) && s1_ok_ff && win;

      if (take) begin
         best_pos_in  = idx_ff + 1'b1;
         best_pri_in  = s1_pri_ff;
         best_v_in    = s1_v_ff;
         best_c_in    = s1_c_ff;
         best_pps_in  = s1_pps_ff;
         best_pw_in   = pw;
         best_dist_in = s1_dist_ff;
         best_low_in  = s1_low_ff;
      end else begin
         best_pos_in  = best_pos_ff;
         best_pri_in  = best_pri_ff;
         best_v_in    = best_v_ff;
         best_c_in    = best_c_ff;
         best_pps_in  = best_pps_ff;
         best_pw_in   = best_pw_ff;
         best_dist_in = best_dist_ff;
         best_low_in  = best_low_ff;
      end

      idx_in = (idx_ff < POS_W'(MAX_OBJECTS)) ? idx_ff + 1'b1 : idx_ff;

      rsp_payload_in = '0;
      if (best_pos_in != '0) begin
         rsp_payload_in.found           = 1'b1;
         rsp_payload_in.object_position = best_pos_in;
         rsp_payload_in.chosen_mv       = best_v_in;
         rsp_payload_in.chosen_ma       = best_c_in;
         rsp_payload_in.is_pps          = best_pps_in;
         rsp_payload_in.request_word    = {1'b0, best_pos_in, 3'b000, 1'b1, 5'd0,
                                           best_low_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (s1_fire && s1_last_ff)) begin
         idx_ff       <= '0;
         best_pos_ff  <= '0;
         best_pri_ff  <= '0;
         best_v_ff    <= '0;
         best_c_ff    <= '0;
         best_pps_ff  <= 1'b0;
         best_pw_ff   <= '0;
         best_dist_ff <= '0;
         best_low_ff  <= '0;
      end else if (s1_fire) begin
         idx_ff       <= idx_in;
         best_pos_ff  <= best_pos_in;
         best_pri_ff  <= best_pri_in;
         best_v_ff    <= best_v_in;
         best_c_ff    <= best_c_in;
         best_pps_ff  <= best_pps_in;
         best_pw_ff   <= best_pw_in;
         best_dist_ff <= best_dist_in;
         best_low_ff  <= best_low_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_payload_ff;

   // A decoded object that cannot move on must still be there in the next cycle.
   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_fire |=> s1_valid_ff)
      else $error("decoded object dropped while stalled");

   // The chosen position never runs ahead of the objects counted.
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      best_pos_ff <= idx_ff)
      else $error("best position beyond object count");

   // Found, a non-zero position and the request flag bit go together.
   a_found_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_payload_ff.found == (rsp_payload_ff.object_position != '0)) &&
                       (rsp_payload_ff.found == rsp_payload_ff.request_word[24]))
      else $error("found flag inconsistent with position or request word");

   // A response with nothing found is all zero.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_payload_ff.found |-> (rsp_payload_ff == '0))
      else $error("not-found response carries data");

endmodule
